// ===== sv/weighted_position_fusion_defines.svh =====
// assertion macros shared by the fusion block
`ifndef WEIGHTED_POSITION_FUSION_DEFINES_SVH
`define WEIGHTED_POSITION_FUSION_DEFINES_SVH

`ifndef SYNTHESIS
`define WPF_ASSERT_IMP(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("wpf assertion failed");
`define WPF_ASSERT_NXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("wpf assertion failed");
`else
`define WPF_ASSERT_IMP(lbl, ante, cons)
`define WPF_ASSERT_NXT(lbl, ante, cons)
`endif

`endif

// ===== sv/wpf_pkg.sv =====
package wpf_pkg;

  localparam int WEIGHT_BITS   = 12;
  localparam int POSITION_BITS = 16;
  localparam int NUM_SRC       = 5;
  localparam int PROD_BITS     = WEIGHT_BITS + POSITION_BITS + 1;
  localparam int SUM_BITS      = WEIGHT_BITS + POSITION_BITS + 3;
  localparam int DEN_BITS      = WEIGHT_BITS + 3;
  localparam int QUOT_BITS     = POSITION_BITS;
  localparam int WREG_BITS     = NUM_SRC * WEIGHT_BITS;
  localparam int THR_BITS      = 15;
  localparam int MASK_BITS     = 2 * NUM_SRC;
  localparam int CFG_ADDR_BITS = 3;
  localparam int CFG_DATA_BITS = WREG_BITS;
  // stage 1 select, two multiply/sum stages, one divider stage per quotient bit
  localparam int PIPE_DEPTH    = 3 + QUOT_BITS;

  localparam logic [CFG_ADDR_BITS-1:0] REG_THRESHOLD = 3'd0;
  localparam logic [CFG_ADDR_BITS-1:0] REG_ENABLE    = 3'd1;
  localparam logic [CFG_ADDR_BITS-1:0] REG_RAD_LOW   = 3'd2;
  localparam logic [CFG_ADDR_BITS-1:0] REG_RAD_HIGH  = 3'd3;
  localparam logic [CFG_ADDR_BITS-1:0] REG_VER_LOW   = 3'd4;
  localparam logic [CFG_ADDR_BITS-1:0] REG_VER_HIGH  = 3'd5;

  typedef struct packed {
    logic               func;
    logic signed [15:0] measured_current;
    logic [31:0]        density_in;
    logic [31:0]        tomo_pair;
    logic [31:0]        electric_pair;
    logic [31:0]        magnetic_pair;
    logic [31:0]        beam_pair;
    logic signed [15:0] cosine_radial;
    logic signed [15:0] sine_vertical;
  } in_t;

  typedef struct packed {
    logic signed [15:0]              current_out;
    logic signed [POSITION_BITS-1:0] fused_radial;
    logic signed [POSITION_BITS-1:0] fused_vertical;
    logic [31:0]                     density_out;
  } out_t;

  typedef struct packed {
    logic               func;
    logic signed [15:0] current;
    logic [31:0]        density;
  } side_t;

  typedef logic [NUM_SRC-1:0][WEIGHT_BITS-1:0]   wvec_t;
  typedef logic [NUM_SRC-1:0][POSITION_BITS-1:0] pvec_t;

endpackage

// ===== sv/wpf_axis.sv =====
module wpf_axis (
  input  logic                                   clk,
  input  logic                                   adv,
  input  wpf_pkg::wvec_t                         w,
  input  wpf_pkg::pvec_t                         p,
  output logic signed [wpf_pkg::SUM_BITS-1:0]    num,
  output logic [wpf_pkg::DEN_BITS-1:0]           den
);

  logic signed [wpf_pkg::PROD_BITS-1:0] prod_r [wpf_pkg::NUM_SRC];
  logic signed [wpf_pkg::PROD_BITS-1:0] prod_nxt [wpf_pkg::NUM_SRC];
  wpf_pkg::wvec_t                       w_r;
  logic signed [wpf_pkg::SUM_BITS-1:0]  num_r, num_nxt;
  logic [wpf_pkg::DEN_BITS-1:0]         den_r, den_nxt;

  always_comb begin
    for (int s = 0; s < wpf_pkg::NUM_SRC; s++) begin
      prod_nxt[s] = $signed({1'b0, w[s]}) * $signed(p[s]);
    end
  end

  always_comb begin
    num_nxt = '0;
    den_nxt = '0;
    for (int s = 0; s < wpf_pkg::NUM_SRC; s++) begin
      num_nxt = num_nxt + wpf_pkg::SUM_BITS'(prod_r[s]);
      den_nxt = den_nxt + wpf_pkg::DEN_BITS'(w_r[s]);
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      prod_r <= prod_nxt;
      w_r    <= w;
      num_r  <= num_nxt;
      den_r  <= den_nxt;
    end
  end

  assign num = num_r;
  assign den = den_r;

endmodule

// ===== sv/wpf_div.sv =====
module wpf_div (
  input  logic                                  clk,
  input  logic                                  adv,
  input  logic signed [wpf_pkg::SUM_BITS-1:0]   num,
  input  logic [wpf_pkg::DEN_BITS-1:0]          den,
  output logic signed [wpf_pkg::QUOT_BITS-1:0]  quot
);

  localparam int QB = wpf_pkg::QUOT_BITS;
  localparam int DW = wpf_pkg::SUM_BITS;

  logic [DW-1:0]                     rem_r [QB];
  logic [QB-1:0]                     q_r   [QB];
  logic                              neg_r [QB];
  logic [wpf_pkg::DEN_BITS-1:0]      d_r   [QB];
  logic [DW-1:0]                     num_abs;

  assign num_abs = num[DW-1] ? DW'(-num) : DW'(num);

  for (genvar k = 0; k < QB; k++) begin : g_stage
    localparam int BIT = QB - 1 - k;
    logic [DW-1:0]               rem_in, shifted, rem_nxt;
    logic [QB-1:0]               q_in, q_nxt;
    logic                        neg_in;
    logic [wpf_pkg::DEN_BITS-1:0] d_in;
    logic                        ge;

    if (k == 0) begin : g_first
      assign rem_in = num_abs;
      assign q_in   = '0;
      assign neg_in = num[DW-1];
      assign d_in   = den;
    end else begin : g_rest
      assign rem_in = rem_r[k-1];
      assign q_in   = q_r[k-1];
      assign neg_in = neg_r[k-1];
      assign d_in   = d_r[k-1];
    end

    always_comb begin
      shifted    = DW'(d_in) << BIT;
      ge         = rem_in >= shifted;
      rem_nxt    = ge ? rem_in - shifted : rem_in;
      q_nxt      = q_in;
      q_nxt[BIT] = ge;
    end

    always_ff @(posedge clk) begin
      if (adv) begin
        rem_r[k] <= rem_nxt;
        q_r[k]   <= q_nxt;
        neg_r[k] <= neg_in;
        d_r[k]   <= d_in;
      end
    end
  end

  // zero weight sum gives zero, sign restored after the magnitude divide
  always_comb begin
    if (d_r[QB-1] == '0) begin
      quot = '0;
    end else if (neg_r[QB-1]) begin
      quot = $signed(-q_r[QB-1]);
    end else begin
      quot = $signed(q_r[QB-1]);
    end
  end

endmodule

// ===== sv/weighted_position_fusion.sv =====
// Weighted position fusion: one request per clock unless the output stalls, each giving
// one result through one select stage, a multiply stage, a sum stage, a 16-stage restoring
// divider producing one quotient bit per stage, then the output register. The divider depth
// sets the latency; throughput is one result per cycle while out_ready is high.
// Configuration writes take effect on the next request and belong to idle periods.
module weighted_position_fusion (
  input  logic                                  clk,
  input  logic                                  rst_n,
  input  logic                                  in_valid,
  output logic                                  in_ready,
  input  wpf_pkg::in_t                          in_data,
  output logic                                  out_valid,
  input  logic                                  out_ready,
  output wpf_pkg::out_t                         out_data,
  input  logic                                  cfg_wr_en,
  input  logic [wpf_pkg::CFG_ADDR_BITS-1:0]     cfg_addr,
  input  logic [wpf_pkg::CFG_DATA_BITS-1:0]     cfg_wdata
);

`include "weighted_position_fusion_defines.svh"

  localparam int NS = wpf_pkg::NUM_SRC;
  localparam int WB = wpf_pkg::WEIGHT_BITS;
  localparam int PB = wpf_pkg::POSITION_BITS;
  localparam int LAT = wpf_pkg::PIPE_DEPTH;

  logic [wpf_pkg::THR_BITS-1:0]  thr_r;
  logic [wpf_pkg::MASK_BITS-1:0] en_r;
  logic [wpf_pkg::WREG_BITS-1:0] rlow_r, rhigh_r, vlow_r, vhigh_r;

  logic                          adv;
  logic [15:0]                   cur_mag;
  logic                          low;
  logic [wpf_pkg::WREG_BITS-1:0] rsel, vsel;
  wpf_pkg::wvec_t                wr_nxt, wv_nxt, wr_r, wv_r;
  wpf_pkg::pvec_t                pr_nxt, pv_nxt, pr_r, pv_r;

  wpf_pkg::side_t                side_r [LAT];
  logic [LAT-1:0]                vld_r;

  logic signed [wpf_pkg::SUM_BITS-1:0] rnum, vnum;
  logic [wpf_pkg::DEN_BITS-1:0]        rden, vden;
  logic signed [PB-1:0]                rq, vq;

  logic                          out_valid_r;
  wpf_pkg::out_t                 out_data_r, out_data_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      thr_r   <= '0;
      en_r    <= '0;
      rlow_r  <= '0;
      rhigh_r <= '0;
      vlow_r  <= '0;
      vhigh_r <= '0;
    end else if (cfg_wr_en) begin
      unique case (cfg_addr)
        wpf_pkg::REG_THRESHOLD: thr_r   <= cfg_wdata[wpf_pkg::THR_BITS-1:0];
        wpf_pkg::REG_ENABLE:    en_r    <= cfg_wdata[wpf_pkg::MASK_BITS-1:0];
        wpf_pkg::REG_RAD_LOW:   rlow_r  <= cfg_wdata;
        wpf_pkg::REG_RAD_HIGH:  rhigh_r <= cfg_wdata;
        wpf_pkg::REG_VER_LOW:   vlow_r  <= cfg_wdata;
        wpf_pkg::REG_VER_HIGH:  vhigh_r <= cfg_wdata;
        default: ;
      endcase
    end
  end

  assign adv      = !out_valid_r || out_ready;
  assign in_ready = adv;

  // -32768 has magnitude 32768, never below a 15-bit threshold
  assign cur_mag = in_data.measured_current[15] ? 16'(-in_data.measured_current)
                                                : 16'(in_data.measured_current);
  assign low  = cur_mag < {1'b0, thr_r};
  assign rsel = low ? rlow_r : rhigh_r;
  assign vsel = low ? vlow_r : vhigh_r;

  always_comb begin
    for (int s = 0; s < NS; s++) begin
      wr_nxt[s] = en_r[s]      ? rsel[s*WB +: WB] : '0;
      wv_nxt[s] = en_r[NS + s] ? vsel[s*WB +: WB] : '0;
    end
    pr_nxt[0] = in_data.tomo_pair[31 -: PB];
    pr_nxt[1] = in_data.electric_pair[31 -: PB];
    pr_nxt[2] = in_data.magnetic_pair[31 -: PB];
    pr_nxt[3] = in_data.cosine_radial[PB-1:0];
    pr_nxt[4] = in_data.beam_pair[31 -: PB];
    pv_nxt[0] = in_data.tomo_pair[PB-1:0];
    pv_nxt[1] = in_data.electric_pair[PB-1:0];
    pv_nxt[2] = in_data.magnetic_pair[PB-1:0];
    pv_nxt[3] = in_data.sine_vertical[PB-1:0];
    pv_nxt[4] = in_data.beam_pair[PB-1:0];
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      wr_r <= wr_nxt;
      wv_r <= wv_nxt;
      pr_r <= pr_nxt;
      pv_r <= pv_nxt;
      side_r[0] <= '{func: in_data.func, current: in_data.measured_current,
                     density: in_data.density_in};
      for (int k = 1; k < LAT; k++) begin
        side_r[k] <= side_r[k-1];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r       <= '0;
      out_valid_r <= 1'b0;
    end else if (adv) begin
      vld_r       <= {vld_r[LAT-2:0], in_valid};
      out_valid_r <= vld_r[LAT-1];
    end
  end

  wpf_axis u_rad_axis (.clk(clk), .adv(adv), .w(wr_r), .p(pr_r), .num(rnum), .den(rden));
  wpf_axis u_ver_axis (.clk(clk), .adv(adv), .w(wv_r), .p(pv_r), .num(vnum), .den(vden));
  wpf_div  u_rad_div  (.clk(clk), .adv(adv), .num(rnum), .den(rden), .quot(rq));
  wpf_div  u_ver_div  (.clk(clk), .adv(adv), .num(vnum), .den(vden), .quot(vq));

  always_comb begin
    out_data_nxt = '0;
    if (side_r[LAT-1].func) begin
      out_data_nxt.current_out    = side_r[LAT-1].current;
      out_data_nxt.fused_radial   = rq;
      out_data_nxt.fused_vertical = vq;
      out_data_nxt.density_out    = side_r[LAT-1].density;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      out_data_r <= out_data_nxt;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  `WPF_ASSERT_IMP(a_ready_when_empty, !out_valid_r, in_ready)
  `WPF_ASSERT_NXT(a_stall_holds_pipe, out_valid_r && !out_ready, $stable(vld_r[LAT-1]))
  `WPF_ASSERT_NXT(a_offline_zero, adv && vld_r[LAT-1] && !side_r[LAT-1].func,
                  out_data_r == '0)

endmodule
